// ----- sv/ksp_pkg.sv -----
package ksp_pkg;

  // Fixed field widths of the stream beats
  localparam int CMD_W    = 2;
  localparam int SID_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  localparam int IN_BITS   = CMD_W + SID_W + DATA_W;
  localparam int OUT_BITS  = STATUS_W + DATA_W + 2;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // highest_stack register after reset
  localparam logic [SID_W-1:0] HIGHEST_RESET = 3'd7;

  // Command codes; the unused code behaves as a query
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_STACK  = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  // Which cached link waits on the link store read data
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_FREE  = 2'd1,
    PEND_STACK = 2'd2
  } pend_t;

  // Result of one operation, minus the value read from the value store
  typedef struct packed {
    status_t status;
    logic    take_val;
    logic    empty;
    logic    full;
  } res_t;

endpackage

// ----- sv/ksp_ram.sv -----
module ksp_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/ksp_ptr_ctrl.sv -----
module ksp_ptr_ctrl #(
  parameter int CAPACITY   = 64,
  parameter int NUM_STACKS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fire,
  input  logic [ksp_pkg::CMD_W-1:0]        cmd,
  input  logic [ksp_pkg::SID_W-1:0]        sid,
  input  logic [ksp_pkg::SID_W-1:0]        highest,
  output ksp_pkg::res_t                    res,
  output logic                             val_wr_en,
  output logic                             val_rd_en,
  output logic [$clog2(CAPACITY)-1:0]      val_addr
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);

  // pointer state; next_r caches the link of each stack top
  logic [PW-1:0]   heads_r   [NUM_STACKS];
  logic [PW-1:0]   heads_nxt [NUM_STACKS];
  logic [PW-1:0]   next_r    [NUM_STACKS];
  logic [PW-1:0]   next_nxt  [NUM_STACKS];
  logic [PW-1:0]   eff_next  [NUM_STACKS];
  logic [PW-1:0]   free_head_r, free_head_nxt;
  logic [PW-1:0]   free_next_r, free_next_nxt;
  // fill count: entries at or above it were never written
  logic [PW-1:0]   hw_r, hw_nxt;
  ksp_pkg::pend_t  pend_r, pend_nxt;
  logic [SW-1:0]   pend_sid_r, pend_sid_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr;
  logic            fresh_r;

  logic            link_we, link_re;
  logic [AW-1:0]   link_wa;
  logic [PW-1:0]   link_wd;
  logic [PW-1:0]   link_rd_data;
  logic [PW-1:0]   lval;
  logic [PW-1:0]   head, nxt, fn, fh;
  logic [SW-1:0]   idx;
  logic            sid_ok;

  ksp_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (PW)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (fire & link_we),
    .wr_addr (link_wa),
    .wr_data (link_wd),
    .rd_en   (fire & link_re),
    .rd_addr (rd_ptr[AW-1:0]),
    .rd_data (link_rd_data)
  );

  // link read result; an untouched entry still holds its reset chain link
  assign lval = fresh_r ? (rd_ptr_r + PW'(1)) : link_rd_data;

  // cached links with the pending read folded in
  always_comb begin
    for (int i = 0; i < NUM_STACKS; i++) begin
      eff_next[i] = (pend_r == ksp_pkg::PEND_STACK && pend_sid_r == SW'(i)) ? lval
                                                                           : next_r[i];
    end
  end

  assign sid_ok = (sid <= highest) && (int'(sid) < NUM_STACKS);
  assign idx    = SW'(sid);
  assign head   = heads_r[idx];
  assign nxt    = eff_next[idx];
  assign fh     = free_head_r;
  assign fn     = (pend_r == ksp_pkg::PEND_FREE) ? lval : free_next_r;

  // operation decode and pointer update
  always_comb begin
    heads_nxt     = heads_r;
    next_nxt      = eff_next;
    free_head_nxt = free_head_r;
    free_next_nxt = fn;
    hw_nxt        = hw_r;
    pend_nxt      = ksp_pkg::PEND_NONE;
    pend_sid_nxt  = pend_sid_r;
    rd_ptr        = NIL;
    link_we       = 1'b0;
    link_re       = 1'b0;
    link_wa       = fh[AW-1:0];
    link_wd       = head;
    val_wr_en     = 1'b0;
    val_rd_en     = 1'b0;
    val_addr      = head[AW-1:0];
    res.status    = ksp_pkg::ST_OK;
    res.take_val  = 1'b0;
    res.empty     = 1'b0;
    if (!sid_ok) begin
      res.status = ksp_pkg::ST_NO_STACK;
    end else begin
      unique case (cmd)
        ksp_pkg::CMD_PUSH: begin
          if (fh == NIL) begin
            res.status = ksp_pkg::ST_OVERFLOW;
          end else begin
            link_we        = 1'b1;
            link_wa        = fh[AW-1:0];
            link_wd        = head;
            val_wr_en      = 1'b1;
            val_addr       = fh[AW-1:0];
            heads_nxt[idx] = fh;
            next_nxt[idx]  = head;
            free_head_nxt  = fn;
            if (fh == hw_r) begin
              hw_nxt = hw_r + PW'(1);
            end
            if (fn == NIL) begin
              free_next_nxt = NIL;
            end else begin
              link_re  = 1'b1;
              rd_ptr   = fn;
              pend_nxt = ksp_pkg::PEND_FREE;
            end
          end
        end
        ksp_pkg::CMD_POP: begin
          if (head == NIL) begin
            res.status = ksp_pkg::ST_UNDERFLOW;
          end else begin
            val_rd_en      = 1'b1;
            val_addr       = head[AW-1:0];
            res.take_val   = 1'b1;
            heads_nxt[idx] = nxt;
            link_we        = 1'b1;
            link_wa        = head[AW-1:0];
            link_wd        = fh;
            free_head_nxt  = head;
            free_next_nxt  = fh;
            if (nxt == NIL) begin
              next_nxt[idx] = NIL;
            end else begin
              link_re      = 1'b1;
              rd_ptr       = nxt;
              pend_nxt     = ksp_pkg::PEND_STACK;
              pend_sid_nxt = idx;
            end
          end
        end
        default: begin
          if (head == NIL) begin
            res.status = ksp_pkg::ST_UNDERFLOW;
          end else begin
            val_rd_en    = 1'b1;
            val_addr     = head[AW-1:0];
            res.take_val = 1'b1;
          end
        end
      endcase
      res.empty = (heads_nxt[idx] == NIL);
    end
    res.full = (free_head_nxt == NIL);
  end

  // state registers advance once per processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        heads_r[i] <= NIL;
        next_r[i]  <= NIL;
      end
      free_head_r <= '0;
      free_next_r <= PW'(1);
      hw_r        <= '0;
      pend_r      <= ksp_pkg::PEND_NONE;
      pend_sid_r  <= '0;
    end else if (fire) begin
      heads_r     <= heads_nxt;
      next_r      <= next_nxt;
      free_head_r <= free_head_nxt;
      free_next_r <= free_next_nxt;
      hw_r        <= hw_nxt;
      pend_r      <= pend_nxt;
      pend_sid_r  <= pend_sid_nxt;
    end
  end

  // address of the outstanding link read and whether it was never written
  always_ff @(posedge clk) begin
    if (fire && link_re) begin
      rd_ptr_r <= rd_ptr;
      fresh_r  <= (rd_ptr >= hw_nxt);
    end
  end

  // pending stack link only for a non-empty stack
  a_pend_stack: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == ksp_pkg::PEND_STACK |-> heads_r[pend_sid_r] != NIL)
    else $error("pending stack link on an empty stack");

  // pending free link only while the free list is non-empty
  a_pend_free: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == ksp_pkg::PEND_FREE |-> free_head_r != NIL)
    else $error("pending free link with an empty free list");

  // an exhausted pool means every entry has been written
  a_full_touched: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r == NIL |-> hw_r == NIL)
    else $error("pool exhausted before all entries were used");

  // a good push puts the old free head on top of the stack
  a_push_top: assert property (@(posedge clk) disable iff (!rst_n)
    fire && sid_ok && cmd == ksp_pkg::CMD_PUSH && res.status == ksp_pkg::ST_OK
    |=> heads_r[$past(idx)] == $past(free_head_r))
    else $error("push did not link the free head on top");

endmodule

// ----- sv/k_stacks_shared_pool.sv -----
// Several LIFO stacks sharing one entry pool through a linked free list.
// in_tdata carries one command beat (push, pop or query of one stack);
// every accepted beat gives exactly one result beat on out_tdata, in order.
// cfg_wr_en/cfg_wr_data write highest_stack; write it only while idle.
// The command is registered in the input register, worked on once the
// result slot is free or draining, and its result beat is registered in
// the result register, which drives out_tvalid.
// Throughput: one beat per cycle while out_tready is high. Each beat does
// one pointer update with at most one link store write, link store read
// and value store access; next links are cached so no beat waits on reads.
// Reset clears the stack tops, the free list head and the fill count; the
// link store needs no clearing pass because entries above the fill count
// read back as their reset chain. highest_stack resets to 7.
// When out_tready is low the result is held, one more command is taken
// into the input register, and then in_tready drops until the result is
// taken.
module k_stacks_shared_pool #(
  parameter int CAPACITY    = 64,
  parameter int NUM_STACKS  = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [ksp_pkg::SID_W-1:0]           cfg_wr_data,  // highest_stack
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [1:0] cmd, [4:2] stack_id, [36:5] push_value, rest zero
  input  logic [ksp_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [1:0] status, [33:2] top_value, [34] stack_empty, [35] pool_full, rest zero
  output logic [ksp_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int AW = $clog2(CAPACITY);

  logic [ksp_pkg::SID_W-1:0]  highest_r;
  logic                       s1_valid_r;
  logic [ksp_pkg::CMD_W-1:0]  s1_cmd_r;
  logic [ksp_pkg::SID_W-1:0]  s1_sid_r;
  logic [ksp_pkg::DATA_W-1:0] s1_pv_r;
  logic                       s2_valid_r;
  ksp_pkg::res_t              s2_res_r;
  ksp_pkg::res_t              res;
  logic                       fire;
  logic                       val_wr_en, val_rd_en;
  logic [AW-1:0]              val_addr;
  logic [VALUE_WIDTH-1:0]     val_rd_data;
  logic [ksp_pkg::DATA_W-1:0] top_value;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      highest_r <= ksp_pkg::HIGHEST_RESET;
    end else if (cfg_wr_en) begin
      highest_r <= cfg_wr_data;
    end
  end

  // a command is processed when its result slot is free or draining
  assign fire      = s1_valid_r & (~s2_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r <= in_tdata[ksp_pkg::CMD_W-1:0];
      s1_sid_r <= in_tdata[ksp_pkg::CMD_W +: ksp_pkg::SID_W];
      s1_pv_r  <= in_tdata[ksp_pkg::CMD_W + ksp_pkg::SID_W +: ksp_pkg::DATA_W];
    end
  end

  ksp_ptr_ctrl #(
    .CAPACITY   (CAPACITY),
    .NUM_STACKS (NUM_STACKS)
  ) u_ptr_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .cmd       (s1_cmd_r),
    .sid       (s1_sid_r),
    .highest   (highest_r),
    .res       (res),
    .val_wr_en (val_wr_en),
    .val_rd_en (val_rd_en),
    .val_addr  (val_addr)
  );

  ksp_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (fire & val_wr_en),
    .wr_addr (val_addr),
    .wr_data (VALUE_WIDTH'($unsigned(s1_pv_r))),
    .rd_en   (fire & val_rd_en),
    .rd_addr (val_addr),
    .rd_data (val_rd_data)
  );

  // result register; the value store read data lines up with it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (fire) begin
      s2_valid_r <= 1'b1;
    end else if (out_tready) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s2_res_r <= res;
    end
  end

  assign top_value  = s2_res_r.take_val ? ksp_pkg::DATA_W'(val_rd_data) : '0;
  assign out_tvalid = s2_valid_r;
  assign out_tdata  = {(ksp_pkg::OUT_TDATA_W - ksp_pkg::OUT_BITS)'(0),
                       s2_res_r.full, s2_res_r.empty, top_value, s2_res_r.status};

endmodule

// ----- bench/k_stacks_shared_pool_tb.sv -----
`timescale 1ns / 1ps

module k_stacks_shared_pool_tb;

  localparam int POOL_SIZE = 64;
  localparam int N_STACKS  = 8;
  localparam int NIL       = POOL_SIZE;   // null pointer, same convention as the block
  localparam int STALL_LIMIT = 500;       // cycles with no beat and no write before giving up
  localparam logic [ksp_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;  // undefined code, acts as a query

  // One result beat, fields in their own types
  typedef struct packed {
    ksp_pkg::status_t           status;
    logic [ksp_pkg::DATA_W-1:0] top;
    logic                       empty;
    logic                       full;
  } stack_res_t;

  // Directed stimulus row; a register write reuses sid as the new highest_stack
  typedef struct packed {
    logic                       is_cfg;
    logic [ksp_pkg::CMD_W-1:0]  cmd;
    logic [ksp_pkg::SID_W-1:0]  sid;
    logic [ksp_pkg::DATA_W-1:0] val;
    logic                       typed;
    stack_res_t                 res;
  } dir_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [ksp_pkg::SID_W-1:0]       cfg_wr_data;
  logic                            in_tvalid;
  logic                            in_tready;
  // [1:0] cmd, [4:2] stack_id, [36:5] push_value
  logic [ksp_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  // [1:0] status, [33:2] top_value, [34] empty, [35] full
  logic [ksp_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Shadow copy of the pool
  logic [ksp_pkg::DATA_W-1:0] pool_val [POOL_SIZE];
  int                         pool_link [POOL_SIZE];
  int                         stack_top [N_STACKS];
  int                         free_ptr;
  logic [ksp_pkg::SID_W-1:0]  highest_cfg;

  stack_res_t pending_results[$];
  int         fails = 0;
  int         quiet_cycles = 0;
  bit         sender_idles = 1'b1;
  bit         no_idle = 1'b0;

  always #1 clk = ~clk;

  k_stacks_shared_pool #(
    .CAPACITY   (POOL_SIZE),
    .NUM_STACKS (N_STACKS),
    .VALUE_WIDTH(ksp_pkg::DATA_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Directed part: edges of the value range, every command, the underflow and no-stack statuses
  localparam int N_DIR = 25;
  dir_row_t dir_tab [N_DIR] = '{
    '{1'b0, ksp_pkg::CMD_QUERY, 3'd0, 32'h0000_0000, 1'b1,
      '{ksp_pkg::ST_UNDERFLOW, 32'h0, 1'b1, 1'b0}},
    '{1'b0, ksp_pkg::CMD_POP,   3'd0, 32'hFFFF_FFFF, 1'b1,
      '{ksp_pkg::ST_UNDERFLOW, 32'h0, 1'b1, 1'b0}},
    '{1'b0, ksp_pkg::CMD_PUSH,  3'd0, 32'h7FFF_FFFF, 1'b1,
      '{ksp_pkg::ST_OK, 32'h0, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_PUSH,  3'd0, 32'h8000_0000, 1'b1,
      '{ksp_pkg::ST_OK, 32'h0, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_QUERY, 3'd0, 32'h0000_0000, 1'b1,
      '{ksp_pkg::ST_OK, 32'h8000_0000, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_POP,   3'd0, 32'h0000_0000, 1'b1,
      '{ksp_pkg::ST_OK, 32'h8000_0000, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_POP,   3'd0, 32'h0000_0000, 1'b1,
      '{ksp_pkg::ST_OK, 32'h7FFF_FFFF, 1'b1, 1'b0}},
    '{1'b0, ksp_pkg::CMD_PUSH,  3'd7, 32'hFFFF_FFFF, 1'b1,
      '{ksp_pkg::ST_OK, 32'h0, 1'b0, 1'b0}},
    '{1'b0, CMD_UNUSED,         3'd7, 32'h0000_0000, 1'b1,
      '{ksp_pkg::ST_OK, 32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_PUSH,  3'd7, 32'h0000_0000, 1'b1,
      '{ksp_pkg::ST_OK, 32'h0, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_POP,   3'd7, 32'hFFFF_FFFF, 1'b1,
      '{ksp_pkg::ST_OK, 32'h0, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_PUSH,  3'd3, 32'hA5A5_A5A5, 1'b0,
      '{ksp_pkg::ST_OK, 32'h0, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_PUSH,  3'd3, 32'h5A5A_5A5A, 1'b0,
      '{ksp_pkg::ST_OK, 32'h0, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_PUSH,  3'd1, 32'h1234_5678, 1'b0,
      '{ksp_pkg::ST_OK, 32'h0, 1'b0, 1'b0}},
    '{1'b1, ksp_pkg::CMD_PUSH,  3'd2, 32'h0000_0000, 1'b0,
      '{ksp_pkg::ST_OK, 32'h0, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_QUERY, 3'd3, 32'h0000_0000, 1'b1,
      '{ksp_pkg::ST_NO_STACK, 32'h0, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_PUSH,  3'd7, 32'hDEAD_BEEF, 1'b1,
      '{ksp_pkg::ST_NO_STACK, 32'h0, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_PUSH,  3'd2, 32'hDEAD_BEEF, 1'b0,
      '{ksp_pkg::ST_OK, 32'h0, 1'b0, 1'b0}},
    '{1'b1, ksp_pkg::CMD_PUSH,  3'd0, 32'h0000_0000, 1'b0,
      '{ksp_pkg::ST_OK, 32'h0, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_POP,   3'd1, 32'h0000_0000, 1'b1,
      '{ksp_pkg::ST_NO_STACK, 32'h0, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_PUSH,  3'd0, 32'h0000_0001, 1'b0,
      '{ksp_pkg::ST_OK, 32'h0, 1'b0, 1'b0}},
    '{1'b1, ksp_pkg::CMD_PUSH,  3'd7, 32'h0000_0000, 1'b0,
      '{ksp_pkg::ST_OK, 32'h0, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_POP,   3'd3, 32'h0000_0000, 1'b0,
      '{ksp_pkg::ST_OK, 32'h0, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_QUERY, 3'd7, 32'h0000_0000, 1'b0,
      '{ksp_pkg::ST_OK, 32'h0, 1'b0, 1'b0}},
    '{1'b0, ksp_pkg::CMD_POP,   3'd1, 32'h0000_0000, 1'b0,
      '{ksp_pkg::ST_OK, 32'h0, 1'b0, 1'b0}}
  };

  // Apply one command to the shadow pool and return the result it gives
  function automatic stack_res_t apply_stack_op(logic [ksp_pkg::CMD_W-1:0] op,
                                                logic [ksp_pkg::SID_W-1:0] sid,
                                                logic [ksp_pkg::DATA_W-1:0] v);
    stack_res_t r;
    int e;
    r = '{ksp_pkg::ST_OK, '0, 1'b0, 1'b0};
    if (sid > highest_cfg) begin
      r.status = ksp_pkg::ST_NO_STACK;
    end else begin
      case (op)
        ksp_pkg::CMD_PUSH: begin
          if (free_ptr == NIL) begin
            r.status = ksp_pkg::ST_OVERFLOW;
          end else begin
            e = free_ptr;
            free_ptr = pool_link[e];
            pool_link[e] = stack_top[sid];
            stack_top[sid] = e;
            pool_val[e] = v;
          end
        end
        ksp_pkg::CMD_POP: begin
          if (stack_top[sid] == NIL) begin
            r.status = ksp_pkg::ST_UNDERFLOW;
          end else begin
            e = stack_top[sid];
            r.top = pool_val[e];
            stack_top[sid] = pool_link[e];
            pool_link[e] = free_ptr;
            free_ptr = e;
          end
        end
        default: begin
          if (stack_top[sid] == NIL) r.status = ksp_pkg::ST_UNDERFLOW;
          else r.top = pool_val[stack_top[sid]];
        end
      endcase
      r.empty = (stack_top[sid] == NIL);
    end
    r.full = (free_ptr == NIL);
    return r;
  endfunction

  // Mostly live stacks, now and then any index
  function automatic logic [ksp_pkg::SID_W-1:0] pick_stack();
    if ($urandom_range(0, 7) == 0) return ksp_pkg::SID_W'($urandom_range(0, N_STACKS - 1));
    return ksp_pkg::SID_W'($urandom_range(0, highest_cfg));
  endfunction

  function automatic logic [ksp_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Random command mix with chosen push and pop shares in percent
  function automatic logic [ksp_pkg::CMD_W-1:0] pick_cmd(int push_pct, int pop_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return ksp_pkg::CMD_PUSH;
    if (roll < push_pct + pop_pct) return ksp_pkg::CMD_POP;
    if (roll < 95) return ksp_pkg::CMD_QUERY;
    return CMD_UNUSED;
  endfunction

  task automatic release_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Drive one beat, wait for it to be taken, then log what it must produce
  task automatic send_beat(logic [ksp_pkg::CMD_W-1:0] op, logic [ksp_pkg::SID_W-1:0] sid,
                           logic [ksp_pkg::DATA_W-1:0] v, bit typed,
                           stack_res_t typed_res);
    stack_res_t r;
    int gap;
    if (sender_idles && !no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      release_input();
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(ksp_pkg::IN_TDATA_W - ksp_pkg::CMD_W - ksp_pkg::SID_W
                    - ksp_pkg::DATA_W){1'b0}}, v, sid, op};
    do @(posedge clk); while (!in_tready);
    r = apply_stack_op(op, sid, v);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic send_random(logic [ksp_pkg::CMD_W-1:0] op);
    send_beat(op, pick_stack(), pick_value(), 1'b0, '0);
  endtask

  // Register write once the block has drained
  task automatic set_highest(logic [ksp_pkg::SID_W-1:0] v);
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    highest_cfg = v;
  endtask

  // Main sequence
  initial begin
    int n_phases;
    logic [ksp_pkg::SID_W-1:0] hs;
    n_phases = 10;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_val[i]  = '0;
      pool_link[i] = i + 1;
    end
    for (int s = 0; s < N_STACKS; s++) stack_top[s] = NIL;
    free_ptr    = 0;
    highest_cfg = ksp_pkg::HIGHEST_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].is_cfg) set_highest(dir_tab[i].sid);
      else send_beat(dir_tab[i].cmd, dir_tab[i].sid, dir_tab[i].val, dir_tab[i].typed,
                     dir_tab[i].res);
    end

    // Random phases: mixed traffic, fill to exhaustion, drain
    for (int p = 0; p < n_phases; p++) begin
      if (p == 0 || p == 2) hs = 3'd7;
      else if (p == 1) hs = 3'd0;
      else hs = ksp_pkg::SID_W'($urandom_range(0, N_STACKS - 1));
      set_highest(hs);
      sender_idles = ($urandom_range(0, 2) != 0);
      no_idle = (p == n_phases - 1);
      case (p % 3)
        0: repeat (70) send_random(pick_cmd(40, 35));
        1: begin
          while (free_ptr != NIL) begin
            if ($urandom_range(0, 9) != 0) send_random(ksp_pkg::CMD_PUSH);
            else send_random(pick_cmd(0, 60));
          end
          repeat (3) send_random(ksp_pkg::CMD_PUSH);
          repeat (3) send_random(pick_cmd(0, 0));
        end
        default: repeat (90) send_random(pick_cmd(10, 75));
      endcase
    end

    release_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Result side back-pressure in random bursts
  initial begin
    int run;
    bit stall;
    out_tready = 1'b0;
    forever begin
      if (no_idle) begin
        @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        stall = ($urandom_range(0, 2) == 0);
        run = stall ? $urandom_range(1, 16) : $urandom_range(1, 40);
        @(negedge clk);
        out_tready <= !stall;
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    stack_res_t got;
    stack_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{ksp_pkg::status_t'(out_tdata[1:0]), out_tdata[33:2],
              out_tdata[34], out_tdata[35]};
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing pending: status=%0d top=%h empty=%b full=%b",
                 $time, got.status, got.top, got.empty, got.full);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.top !== want.top ||
            got.empty !== want.empty || got.full !== want.full) begin
          $display("%0t: mismatch expected status=%0d top=%h empty=%b full=%b", $time,
                   want.status, want.top, want.empty, want.full);
          $display("%0t:          actual   status=%0d top=%h empty=%b full=%b", $time,
                   got.status, got.top, got.empty, got.full);
          fails++;
        end
      end
    end
  end

  // Watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
